### rtl/md5_hash_engine_top_macros.svh
// ----------------------------------------------------------------------------
// md5 engine assertion macros
// shared assertion shorthands for the md5 engine
// ----------------------------------------------------------------------------
`ifndef MD5_HASH_ENGINE_TOP_MACROS_SVH
`define MD5_HASH_ENGINE_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define MD5_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MD5_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5 package
// constants, tables and the front-to-back queue entry type
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // queue entry: one classified item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_item;
  } md5_item_t;

  function automatic logic [31:0] sine_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] idx;
    case (r[5:4])
      2'd0: idx = r[3:0];
      2'd1: idx = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2: idx = 4'(r[3:0] * 4'd3 + 4'd5);
      default: idx = 4'(r[3:0] * 4'd7);
    endcase
    return idx;
  endfunction

endpackage

### rtl/md5_hash_engine_top.sv
// ----------------------------------------------------------------------------
// md5 hash engine top
// streaming md5 digest of a byte message
// ----------------------------------------------------------------------------
// channel | dir | tdata                 | tuser         | tlast
// s_axis  | in  | data_byte             | byte_present  | last_item
// m_axis  | out | digest_low,digest_high| -             | -
// a byte item passes through a two-entry queue and is packed when the back end takes it
// the 64th byte of a block holds the back end for 64 rounds and one add
// a last item adds a pad state and one or two blocks
// two blocks when 56 or more bytes are buffered or its byte fills a block
// reset restores the initial chaining values; no clearing pass
// a held digest blocks only the next last item; the queue then fills and stalls
module md5_hash_engine_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // byte_present
  input  logic         s_axis_tlast,   // last_item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_low, digest_high
);

  md5_pkg::md5_item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item.data_byte    = s_axis_tdata;
  assign in_item.byte_present = s_axis_tuser;
  assign in_item.last_item    = s_axis_tlast;

  md5_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  md5_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );

endmodule

### rtl/md5_front.sv
// ----------------------------------------------------------------------------
// md5 front
// accepts items, drops empty ones and queues the rest for the back end
// ----------------------------------------------------------------------------
module md5_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  md5_pkg::md5_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output md5_pkg::md5_item_t q_item_o
);

  localparam int unsigned PtrW = $clog2(md5_pkg::QueueDepth);

  md5_pkg::md5_item_t mem_q [md5_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop, keep;

  assign in_ready_o = (cnt_q != (PtrW+1)'(md5_pkg::QueueDepth));
  // items with neither flag do nothing
  assign keep = in_item_i.byte_present | in_item_i.last_item;
  assign push = in_valid_i & in_ready_o & keep;
  assign pop  = q_valid_o & q_ready_i;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(md5_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(md5_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

### rtl/md5_back.sv
// ----------------------------------------------------------------------------
// md5 back
// packs bytes, pads, runs one md5 round per cycle and emits the digest
// ----------------------------------------------------------------------------
`include "md5_hash_engine_top_macros.svh"

module md5_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  md5_pkg::md5_item_t q_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [127:0]       out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRound = 3'd1;
  localparam logic [2:0] StPad   = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;

  logic [2:0]  st_q, st_d;
  logic [31:0] blk_q [16];
  logic [31:0] ch_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] bits_q;
  logic [5:0]  fill_q, rnd_q;
  logic        fin_q;   // current compression belongs to the end sequence
  logic        pad_q;   // padding already written for this message
  logic        two_q;   // a length block still follows
  logic        ov_q;
  logic [127:0] out_q;

  logic [31:0] f, sum, rot, nb;
  logic [1:0]  stg;

  assign stg = rnd_q[5:4];
  always_comb begin
    case (stg)
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum = a_q + f + blk_q[md5_pkg::msg_index(rnd_q)] + md5_pkg::sine_const(rnd_q);
    rot = (sum << md5_pkg::rot_amount(rnd_q))
        | (sum >> (6'd32 - {1'b0, md5_pkg::rot_amount(rnd_q)}));
    nb  = b_q + rot;
  end

  // a held digest only blocks the next last item
  assign q_ready_o   = (st_q == StIdle) && !(ov_q && q_item_i.last_item);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  logic take;
  assign take = q_valid_i & q_ready_o;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (take) begin
                 if (q_item_i.byte_present && fill_q == 6'd63) st_d = StRound;
                 else if (q_item_i.last_item) st_d = StPad;
               end
      StRound: if (rnd_q == 6'd63) st_d = StFinal;
      StPad:   st_d = StRound;
      StFinal: begin
        if (!fin_q) st_d = StIdle;
        else if (!pad_q) st_d = StPad;
        else if (two_q) st_d = StRound;
        else st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    logic [3:0] w;
    logic [1:0] bp;
    w  = fill_q[5:2];
    bp = fill_q[1:0];
    if (st_q == StIdle && take && q_item_i.byte_present) begin
      if (bp == 2'd0) blk_q[w] <= {24'd0, q_item_i.data_byte};
      else blk_q[w][bp*8 +: 8] <= q_item_i.data_byte;
    end
    if (st_q == StPad) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) == w) begin
          if (bp == 2'd0) blk_q[i] <= 32'h80;
          else blk_q[i][bp*8 +: 8] <= 8'h80;
        end else if (4'(i) > w) begin
          if (fill_q < 6'd56 && i == 14) blk_q[i] <= bits_q[31:0];
          else if (fill_q < 6'd56 && i == 15) blk_q[i] <= bits_q[63:32];
          else blk_q[i] <= '0;
        end
      end
    end
    if (st_q == StFinal && fin_q && two_q) begin
      for (int i = 0; i < 14; i++) blk_q[i] <= '0;
      blk_q[14] <= bits_q[31:0];
      blk_q[15] <= bits_q[63:32];
    end
    if (st_q == StRound) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= nb;
    end else if (st_q == StFinal) begin
      a_q <= ch_q[0] + a_q;
      b_q <= ch_q[1] + b_q;
      c_q <= ch_q[2] + c_q;
      d_q <= ch_q[3] + d_q;
    end else begin
      a_q <= ch_q[0];
      b_q <= ch_q[1];
      c_q <= ch_q[2];
      d_q <= ch_q[3];
    end
    if (st_q == StFinal && fin_q && pad_q && !two_q) begin
      out_q <= {ch_q[3] + d_q, ch_q[2] + c_q, ch_q[1] + b_q, ch_q[0] + a_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      ch_q[0] <= md5_pkg::InitA;
      ch_q[1] <= md5_pkg::InitB;
      ch_q[2] <= md5_pkg::InitC;
      ch_q[3] <= md5_pkg::InitD;
      bits_q <= '0;
      fill_q <= '0;
      rnd_q  <= '0;
      fin_q  <= 1'b0;
      pad_q  <= 1'b0;
      two_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (st_q)
        StIdle: if (take) begin
          fin_q <= q_item_i.last_item;
          if (q_item_i.byte_present) begin
            fill_q <= fill_q + 6'd1;
            bits_q <= bits_q + 64'd8;
          end
        end
        StPad: begin
          two_q <= (fill_q >= 6'd56);
          pad_q <= 1'b1;
        end
        StRound: rnd_q <= rnd_q + 6'd1;
        StFinal: begin
          if (fin_q && pad_q && !two_q) begin
            ov_q   <= 1'b1;
            fin_q  <= 1'b0;
            pad_q  <= 1'b0;
            bits_q <= '0;
            fill_q <= '0;
            ch_q[0] <= md5_pkg::InitA;
            ch_q[1] <= md5_pkg::InitB;
            ch_q[2] <= md5_pkg::InitC;
            ch_q[3] <= md5_pkg::InitD;
          end else begin
            if (two_q) two_q <= 1'b0;
            ch_q[0] <= ch_q[0] + a_q;
            ch_q[1] <= ch_q[1] + b_q;
            ch_q[2] <= ch_q[2] + c_q;
            ch_q[3] <= ch_q[3] + d_q;
          end
        end
        default: ;
      endcase
    end
  end

  `MD5_ASSERT_IMP(a_rnd_idle, clk_i, rst_ni, st_q != StRound, rnd_q == 6'd0, "round count not idle")
  `MD5_ASSERT_NXT(a_pad_round, clk_i, rst_ni, st_q == StPad, st_q == StRound, "pad not followed by round")
  `MD5_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, ov_q && q_item_i.last_item, !q_ready_o, "last item taken while result held")

endmodule
